[design/dsi_manchester_frame_generator_unit_assert.svh]
// Assertion macros shared by the frame generator RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef DSI_MANCHESTER_FRAME_GENERATOR_UNIT_ASSERT_SVH
`define DSI_MANCHESTER_FRAME_GENERATOR_UNIT_ASSERT_SVH

// Plain condition checked at every edge out of reset.
`define DMFG_ASSERT(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("dmfg check failed");

// Antecedent in one cycle implies consequent in the next.
`define DMFG_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dmfg check failed");

`endif

[design/dmfg_pkg.sv]
// Types and constants of the DSI Manchester frame generator.
// No dependencies.
package dmfg_pkg;

	localparam int NUM_CH     = 8;
	localparam int LEVEL_W    = 8;
	localparam int TICK_W     = 8;
	localparam int HALF_BITS  = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [TICK_W-1:0] DATA_TICKS       = 8'd16;
	localparam logic [TICK_W-1:0] TICK_MAX         = 8'hFF;
	localparam logic [TICK_W-1:0] PAUSE_TICKS_RST  = 8'd79;
	localparam logic [TICK_W-1:0] START_TICKS_RST  = 8'd1;
	localparam logic [TICK_W-1:0] END_TICKS_RST    = 8'd4;

	typedef enum logic [1:0] {
		PH_PAUSE = 2'd0,
		PH_START = 2'd1,
		PH_DATA  = 2'd2,
		PH_END   = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAUSE_TICKS = 2'd0,
		CFG_START_TICKS = 2'd1,
		CFG_END_TICKS   = 2'd2
	} cfg_idx_t;

	// Strobes from the sequencer to the half-bit ring.
	typedef struct packed {
		logic load;
		logic shift;
	} ring_ctl_t;

endpackage

[design/dmfg_if.sv]
// Handshake channels of the frame generator: tick input, result, config write.
// Depends on dmfg_pkg.
interface dmfg_in_if;
	logic valid;
	logic ready;
	logic [dmfg_pkg::LEVEL_W-1:0] level_ch0;
	logic [dmfg_pkg::LEVEL_W-1:0] level_ch1;
	logic [dmfg_pkg::LEVEL_W-1:0] level_ch2;
	logic [dmfg_pkg::LEVEL_W-1:0] level_ch3;
	logic [dmfg_pkg::LEVEL_W-1:0] level_ch4;
	logic [dmfg_pkg::LEVEL_W-1:0] level_ch5;
	logic [dmfg_pkg::LEVEL_W-1:0] level_ch6;
	logic [dmfg_pkg::LEVEL_W-1:0] level_ch7;
	modport source (output valid, level_ch0, level_ch1, level_ch2, level_ch3,
		level_ch4, level_ch5, level_ch6, level_ch7, input ready);
	modport sink (input valid, level_ch0, level_ch1, level_ch2, level_ch3,
		level_ch4, level_ch5, level_ch6, level_ch7, output ready);
endinterface

interface dmfg_out_if;
	logic valid;
	logic ready;
	logic [dmfg_pkg::NUM_CH-1:0] line_levels;
	logic [1:0] frame_phase;
	modport source (output valid, line_levels, frame_phase, input ready);
	modport sink (input valid, line_levels, frame_phase, output ready);
endinterface

interface dmfg_cfg_if;
	logic valid;
	logic ready;
	logic [dmfg_pkg::CFG_IDX_W-1:0] index;
	logic [dmfg_pkg::TICK_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/dmfg_cell.sv]
// One cell of the half-bit ring: holds one column (one half-bit of all lines).
// Depends on dmfg_pkg.
module dmfg_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dmfg_pkg::ring_ctl_t          ctl,
	input  logic [dmfg_pkg::NUM_CH-1:0]  load_col,
	input  logic [dmfg_pkg::NUM_CH-1:0]  next_col,
	output logic [dmfg_pkg::NUM_CH-1:0]  col
);

	logic [dmfg_pkg::NUM_CH-1:0] col_q;

	// Store resets to zeros: first data phase after reset is all low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctl.load) begin
			col_q <= load_col;
		end else if (ctl.shift) begin
			col_q <= next_col;
		end
	end

	assign col = col_q;

endmodule

[design/dmfg_seq.sv]
// Phase sequencer: phase and tick counter, ring load/shift strobes.
// Depends on dmfg_pkg and the assertion macro header.
`include "dsi_manchester_frame_generator_unit_assert.svh"

module dmfg_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [dmfg_pkg::TICK_W-1:0]  pause_len,
	input  logic [dmfg_pkg::TICK_W-1:0]  start_len,
	input  logic [dmfg_pkg::TICK_W-1:0]  end_len,
	output dmfg_pkg::ring_ctl_t          ctl,
	output dmfg_pkg::phase_t             phase_cur
);

	dmfg_pkg::phase_t phase_q, phase_d;
	logic [dmfg_pkg::TICK_W-1:0] tick_q, tick_d;
	logic [dmfg_pkg::TICK_W-1:0] len;
	logic [dmfg_pkg::TICK_W-1:0] tc;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dmfg_pkg::PH_PAUSE;
			tick_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
		end
	end

	always_comb begin
		unique case (phase_q)
			dmfg_pkg::PH_PAUSE: len = pause_len;
			dmfg_pkg::PH_START: len = start_len;
			dmfg_pkg::PH_DATA:  len = dmfg_pkg::DATA_TICKS;
			dmfg_pkg::PH_END:   len = end_len;
		endcase
		// leave once count reaches length (zero acts like one)
		adv = (tick_q >= len);
		phase_d = adv ? dmfg_pkg::phase_t'(phase_q + 2'd1) : phase_q;
		tc = adv ? '0 : tick_q;
		tick_d = (tc == dmfg_pkg::TICK_MAX) ? tc : tc + 1'b1;
		ctl.load  = step && adv && (phase_q == dmfg_pkg::PH_END);
		ctl.shift = step && (phase_d == dmfg_pkg::PH_DATA);
		phase_cur = phase_d;
	end

	`DMFG_ASSERT(a_load_shift_excl, clk, arst_n, !(ctl.load && ctl.shift))
	`DMFG_ASSERT(a_data_count_bound, clk, arst_n,
		(phase_q != dmfg_pkg::PH_DATA) || (tick_q <= dmfg_pkg::DATA_TICKS))
	`DMFG_ASSERT(a_tick_no_wrap, clk, arst_n, !step || (tick_d != '0))

endmodule

[design/dsi_manchester_frame_generator_unit.sv]
// DSI Manchester frame generator, eight lines: sequencer plus a 16-cell ring.
// An accepted tick item's result item is registered, offered the cycle after.
// One item per clock unless stalled; the ring shifts a column per data tick.
// A held result blocks input until taken; taking it frees the slot that cycle.
// Reset (arst_n low, async): phase pause, tick count 0, ring all zeros,
// lengths 79/1/4, no result pending.
`include "dsi_manchester_frame_generator_unit_assert.svh"

module dsi_manchester_frame_generator_unit (
	input  logic        clk,
	input  logic        arst_n,
	dmfg_in_if.sink     tick_ch,
	dmfg_out_if.source  result_ch,
	dmfg_cfg_if.sink    cfg
);

	localparam int NCH = dmfg_pkg::NUM_CH;
	localparam int NHB = dmfg_pkg::HALF_BITS;

	// Configuration registers
	logic [dmfg_pkg::TICK_W-1:0] pause_len_q, start_len_q, end_len_q;

	// Result register
	logic                  out_valid_q;
	logic [NCH-1:0]        out_lines_q;
	dmfg_pkg::phase_t      out_phase_q;

	logic                  in_fire;
	dmfg_pkg::ring_ctl_t   ctl;
	dmfg_pkg::phase_t      phase_cur;
	logic [NCH-1:0]        lines;

	logic [NCH-1:0] levels [NCH];
	logic [NCH-1:0] load_cols [NHB];
	logic [NCH-1:0] cols [NHB];

	// Config writes always taken; indexes past the list are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_len_q <= dmfg_pkg::PAUSE_TICKS_RST;
			start_len_q <= dmfg_pkg::START_TICKS_RST;
			end_len_q   <= dmfg_pkg::END_TICKS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				dmfg_pkg::CFG_PAUSE_TICKS: pause_len_q <= cfg.data;
				dmfg_pkg::CFG_START_TICKS: start_len_q <= cfg.data;
				dmfg_pkg::CFG_END_TICKS:   end_len_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// Take a tick whenever the result slot is empty or being drained.
	assign tick_ch.ready = !out_valid_q || result_ch.ready;
	assign in_fire = tick_ch.valid && tick_ch.ready;

	dmfg_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (in_fire),
		.pause_len (pause_len_q),
		.start_len (start_len_q),
		.end_len   (end_len_q),
		.ctl       (ctl),
		.phase_cur (phase_cur)
	);

	// Manchester columns: half-bit 2k carries bit 7-k (one -> high first),
	// half-bit 2k+1 its complement. Column k holds that half-bit of all lines.
	assign levels[0] = tick_ch.level_ch0;
	assign levels[1] = tick_ch.level_ch1;
	assign levels[2] = tick_ch.level_ch2;
	assign levels[3] = tick_ch.level_ch3;
	assign levels[4] = tick_ch.level_ch4;
	assign levels[5] = tick_ch.level_ch5;
	assign levels[6] = tick_ch.level_ch6;
	assign levels[7] = tick_ch.level_ch7;

	always_comb begin
		for (int k = 0; k < NHB / 2; k++) begin
			for (int i = 0; i < NCH; i++) begin
				load_cols[2*k][i]   = levels[i][dmfg_pkg::LEVEL_W-1-k];
				load_cols[2*k+1][i] = ~levels[i][dmfg_pkg::LEVEL_W-1-k];
			end
		end
	end

	// Ring of half-bit cells. Each data tick every cell takes its upper
	// neighbor's column and cell 0 wraps to the top; after 16 data ticks the
	// ring is back in place. Cell 0 always holds the column for this tick.
	for (genvar k = 0; k < NHB; k++) begin : g_cell
		localparam int NXT = (k + 1) % NHB;
		dmfg_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.load_col (load_cols[k]),
			.next_col (cols[NXT]),
			.col      (cols[k])
		);
	end

	always_comb begin
		unique case (phase_cur)
			dmfg_pkg::PH_START: lines = '1;
			dmfg_pkg::PH_DATA:  lines = cols[0];
			dmfg_pkg::PH_PAUSE: lines = '0;
			dmfg_pkg::PH_END:   lines = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_lines_q <= lines;
			out_phase_q <= phase_cur;
		end
	end

	assign result_ch.valid       = out_valid_q;
	assign result_ch.line_levels = out_lines_q;
	assign result_ch.frame_phase = out_phase_q;

	`DMFG_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, in_fire, out_valid_q)
	`DMFG_ASSERT(a_start_all_high, clk, arst_n,
		!out_valid_q || (out_phase_q != dmfg_pkg::PH_START) || (out_lines_q == '1))
	`DMFG_ASSERT(a_idle_phases_low, clk, arst_n,
		!out_valid_q || (out_phase_q == dmfg_pkg::PH_START) ||
		(out_phase_q == dmfg_pkg::PH_DATA) || (out_lines_q == '0))

endmodule

[tb/tb_dsi_manchester_frame_generator_unit.sv]
// Testbench of the DSI Manchester frame generator: random and directed ticks
// against a built-in frame predictor, with random stalls on both channels.
// Depends on dmfg_pkg, the dmfg interfaces and dsi_manchester_frame_generator_unit.
`timescale 1ns / 100ps

typedef logic [dmfg_pkg::NUM_CH-1:0][dmfg_pkg::LEVEL_W-1:0] tick_levels_t;

typedef struct packed {
	logic [dmfg_pkg::NUM_CH-1:0] lines;
	dmfg_pkg::phase_t phase;
} line_state_t;

class frame_scoreboard;
	// lengths and sequencer state of the predicted generator
	logic [7:0] pause_len;
	logic [7:0] start_len;
	logic [7:0] end_len;
	dmfg_pkg::phase_t cur_phase;
	logic [7:0] tick_cnt;
	logic [15:0] halfbits [dmfg_pkg::NUM_CH];
	line_state_t expected_lines [$];
	int mismatches;

	function new();
		pause_len = dmfg_pkg::PAUSE_TICKS_RST;
		start_len = dmfg_pkg::START_TICKS_RST;
		end_len = dmfg_pkg::END_TICKS_RST;
		cur_phase = dmfg_pkg::PH_PAUSE;
		tick_cnt = '0;
		foreach (halfbits[c])
			halfbits[c] = '0;
		mismatches = 0;
	endfunction

	function void set_length(dmfg_pkg::cfg_idx_t idx, logic [7:0] val);
		case (idx)
			dmfg_pkg::CFG_PAUSE_TICKS: pause_len = val;
			dmfg_pkg::CFG_START_TICKS: start_len = val;
			dmfg_pkg::CFG_END_TICKS:   end_len = val;
			default: ;
		endcase
	endfunction

	function int pending();
		return expected_lines.size();
	endfunction

	function void report(string what, int exp_val, int act_val);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch, expected %0h, got %0h",
				$time, what, exp_val, act_val);
	endfunction

	// Called for every accepted tick item.
	function void note_tick(tick_levels_t lv);
		line_state_t e;
		logic [7:0] len;
		logic [15:0] w;
		case (cur_phase)
			dmfg_pkg::PH_PAUSE: len = pause_len;
			dmfg_pkg::PH_START: len = start_len;
			dmfg_pkg::PH_DATA:  len = dmfg_pkg::DATA_TICKS;
			default:            len = end_len;
		endcase
		if (tick_cnt >= len) begin
			case (cur_phase)
				dmfg_pkg::PH_PAUSE: cur_phase = dmfg_pkg::PH_START;
				dmfg_pkg::PH_START: cur_phase = dmfg_pkg::PH_DATA;
				dmfg_pkg::PH_DATA:  cur_phase = dmfg_pkg::PH_END;
				default:            cur_phase = dmfg_pkg::PH_PAUSE;
			endcase
			tick_cnt = '0;
			// latch and encode on pause entry, MSB first: 1 -> high,low; 0 -> low,high
			if (cur_phase == dmfg_pkg::PH_PAUSE) begin
				for (int c = 0; c < dmfg_pkg::NUM_CH; c++) begin
					w = '0;
					for (int k = 0; k < 8; k++) begin
						if (lv[c][7 - k])
							w[2 * k] = 1'b1;
						else
							w[2 * k + 1] = 1'b1;
					end
					halfbits[c] = w;
				end
			end
		end
		e.phase = cur_phase;
		e.lines = '0;
		if (cur_phase == dmfg_pkg::PH_START)
			e.lines = '1;
		else if (cur_phase == dmfg_pkg::PH_DATA)
			for (int c = 0; c < dmfg_pkg::NUM_CH; c++)
				e.lines[c] = halfbits[c][tick_cnt[3:0]];
		expected_lines.push_back(e);
		if (tick_cnt != dmfg_pkg::TICK_MAX)
			tick_cnt++;
	endfunction

	// Called for every accepted result item.
	function void check_result(logic [dmfg_pkg::NUM_CH-1:0] lines, logic [1:0] ph);
		line_state_t e;
		if (expected_lines.size() == 0) begin
			report("unexpected result, line_levels", 0, lines);
			return;
		end
		e = expected_lines.pop_front();
		if (lines !== e.lines)
			report("line_levels", e.lines, lines);
		if (ph !== e.phase)
			report("frame_phase", e.phase, ph);
	endfunction
endclass

module tb_dsi_manchester_frame_generator_unit;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dmfg_in_if  in_ch ();
	dmfg_out_if out_ch ();
	dmfg_cfg_if cfg_ch ();

	dsi_manchester_frame_generator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_ch   (in_ch),
		.result_ch (out_ch),
		.cfg       (cfg_ch)
	);

	frame_scoreboard sb;

	// idle rates in percent, and a long receiver hold-off counted in cycles
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int rcv_hold = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: ready changes on the falling edge only.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				out_ch.ready = 1'b0;
			end else if (rcv_hold > 0) begin
				out_ch.ready = 1'b0;
				rcv_hold--;
			end else begin
				out_ch.ready = ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Results are taken at the rising edge, before the block's registers move.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.line_levels, out_ch.frame_phase);
	end

	// Offers one tick item, with random idle cycles ahead of it.
	// Entered and left at a falling edge.
	task automatic send_tick(input tick_levels_t lv);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.level_ch0 = lv[0];
		in_ch.level_ch1 = lv[1];
		in_ch.level_ch2 = lv[2];
		in_ch.level_ch3 = lv[3];
		in_ch.level_ch4 = lv[4];
		in_ch.level_ch5 = lv[5];
		in_ch.level_ch6 = lv[6];
		in_ch.level_ch7 = lv[7];
		do @(posedge clk); while (!in_ch.ready);
		sb.note_tick(lv);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input dmfg_pkg::cfg_idx_t idx, input logic [7:0] val);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = val;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_length(idx, val);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Lengths change only with the block idle; every tick yields a result,
	// so the register writes wait until the result queue has drained.
	task automatic set_lengths(input logic [7:0] p_len, input logic [7:0] s_len,
			input logic [7:0] e_len);
		in_ch.valid = 1'b0;
		wait_drained();
		repeat (3) @(negedge clk);
		write_reg(dmfg_pkg::CFG_PAUSE_TICKS, p_len);
		write_reg(dmfg_pkg::CFG_START_TICKS, s_len);
		write_reg(dmfg_pkg::CFG_END_TICKS, e_len);
	endtask

	// Random ticks. Mostly random bytes, some all-zero and all-one bytes.
	// With pressure set, the receiver holds off for a long stretch while
	// ticks keep coming, and later the sender waits for the queue to empty.
	task automatic run_random(input int count, input bit pressure);
		tick_levels_t lv;
		int pick;
		for (int n = 0; n < count; n++) begin
			for (int c = 0; c < dmfg_pkg::NUM_CH; c++) begin
				pick = $urandom_range(9);
				if (pick == 0)
					lv[c] = 8'h00;
				else if (pick == 1)
					lv[c] = 8'hFF;
				else
					lv[c] = 8'($urandom_range(255));
			end
			if (pressure && n == count / 3)
				rcv_hold = 80;
			if (pressure && n == (2 * count) / 3) begin
				in_ch.valid = 1'b0;
				wait_drained();
			end
			send_tick(lv);
		end
	endtask

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [7:0] patterns [6];
		tick_levels_t lv;
		int w;
		patterns = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55};
		sb = new();
		in_ch.valid = 1'b0;
		in_ch.level_ch0 = '0;
		in_ch.level_ch1 = '0;
		in_ch.level_ch2 = '0;
		in_ch.level_ch3 = '0;
		in_ch.level_ch4 = '0;
		in_ch.level_ch5 = '0;
		in_ch.level_ch6 = '0;
		in_ch.level_ch7 = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = dmfg_pkg::CFG_PAUSE_TICKS;
		cfg_ch.data = '0;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: all lengths zero before the first tick, so pause is left
		// on the very first tick and the first data phase sends the all-zero
		// store. The tick entering pause then latches mixed extreme bytes.
		snd_idle_pct = 17;
		rcv_idle_pct = 62;
		set_lengths(8'd0, 8'd0, 8'd0);
		for (int i = 0; i < 24; i++) begin
			for (int c = 0; c < dmfg_pkg::NUM_CH; c++)
				lv[c] = patterns[(i + c) % 6];
			send_tick(lv);
		end

		// Shortest real frames, sender idling now and then, receiver often.
		set_lengths(8'd1, 8'd1, 8'd1);
		run_random(350, 1'b0);

		// Small random lengths, the idle rates swapped.
		snd_idle_pct = 62;
		rcv_idle_pct = 17;
		set_lengths(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
			8'($urandom_range(1, 8)));
		run_random(350, 1'b0);

		// Longest lengths, no idling, plus the long stall and the drain pause.
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		set_lengths(8'd255, 8'd255, 8'd255);
		run_random(300, 1'b1);

		// Back to the power-on lengths; the count is likely past the new
		// length here, so the current phase should end on the next tick.
		set_lengths(dmfg_pkg::PAUSE_TICKS_RST, dmfg_pkg::START_TICKS_RST,
			dmfg_pkg::END_TICKS_RST);
		run_random(250, 1'b0);
		in_ch.valid = 1'b0;

		w = 0;
		while (w < 1000 && sb.pending() != 0) begin
			@(negedge clk);
			w++;
		end
		repeat (5) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
